[src/ddsc_pkg.sv]
`timescale 1ns / 1ps
// ddsc_pkg: widths, register indexes, waveform codes and constants of the DDS
// oscillator. Used by the bit-serial multiplier, the divider and the top level.
package ddsc_pkg;

  // default parameter values
  localparam int unsigned PHASE_BITS_DEF = 32;
  localparam int unsigned SINE_DEPTH_DEF = 1024;  // power of two

  // field widths
  localparam int unsigned FREQ_W     = 19;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned WAVE_W     = 2;
  localparam int unsigned DETUNE_W   = 16;
  localparam int unsigned CUTOFF_W   = 15;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned SR_W       = 18;
  localparam int unsigned MAG_W      = 17;

  // shared multiplier: a is the multiplicand, b is consumed one bit a cycle
  localparam int unsigned MUL_AW = 21;
  localparam int unsigned MUL_BW = 19;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned MUL_CW = $clog2(MUL_BW + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETUNE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTORTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd4;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;

  // register reset values
  localparam logic [WAVE_W-1:0]   WAVEFORM_RST = WAVE_SINE;
  localparam logic [DETUNE_W-1:0] DETUNE_RST   = 16'd6554;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST   = 15'd1000;
  localparam logic [DIST_W-1:0]   DIST_RST     = 16'd13107;
  localparam logic [SR_W-1:0]     SR_RST       = 18'd44100;

  // arithmetic constants
  localparam int unsigned DETUNE_SCALE = 52429;   // 0.05 in Q20 per Q16 step
  localparam int unsigned SINE_C5      = 4926;
  localparam int unsigned SINE_C3      = 42334;
  localparam int unsigned SINE_C1      = 102944;
  localparam int unsigned QUARTER_Q14  = 16384;
  localparam int unsigned ONE_Q16      = 65536;
  localparam int unsigned DIST_HALF    = 32768;
  localparam int unsigned GAIN_DIV     = 40000;
  localparam int unsigned GAIN_HALF    = 20000;
  localparam int unsigned GAIN_W       = 32;
  localparam int unsigned TANH_LAST    = 63179;

  // tanh breakpoints at steps of 1/8, Q16
  function automatic logic [15:0] tanh_pt(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd8150;
      5'd2:    v = 16'd16051;
      5'd3:    v = 16'd23485;
      5'd4:    v = 16'd30285;
      5'd5:    v = 16'd36346;
      5'd6:    v = 16'd41625;
      5'd7:    v = 16'd46131;
      5'd8:    v = 16'd49912;
      5'd9:    v = 16'd53038;
      5'd10:   v = 16'd55593;
      5'd11:   v = 16'd57660;
      5'd12:   v = 16'd59320;
      5'd13:   v = 16'd60644;
      5'd14:   v = 16'd61694;
      5'd15:   v = 16'd62524;
      default: v = 16'd63179;
    endcase
    return v;
  endfunction

endpackage

[src/ddsc_mul.sv]
`timescale 1ns / 1ps
// ddsc_mul: unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ddsc_pkg for operand widths.
module ddsc_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ddsc_pkg::MUL_AW-1:0]   a_i,
  input  logic [ddsc_pkg::MUL_BW-1:0]   b_i,
  output logic                          done_o,
  output logic [ddsc_pkg::MUL_PW-1:0]   p_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [ddsc_pkg::MUL_CW-1:0]   cnt_q;
  logic [ddsc_pkg::MUL_AW-1:0]   a_q;
  logic [ddsc_pkg::MUL_PW-1:0]   p_q, p_d;
  logic [ddsc_pkg::MUL_AW:0]     sum;

  always_comb begin
    sum = {1'b0, p_q[ddsc_pkg::MUL_PW-1:ddsc_pkg::MUL_BW]}
        + (p_q[0] ? {1'b0, a_q} : '0);
    p_d = {sum, p_q[ddsc_pkg::MUL_BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ddsc_pkg::MUL_CW'(ddsc_pkg::MUL_BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ddsc_pkg::MUL_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{ddsc_pkg::MUL_AW{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

[src/ddsc_div.sv]
`timescale 1ns / 1ps
// ddsc_div: restoring divider, one quotient bit per cycle, dividend fed MSB first.
// Depends on ddsc_pkg for the divisor width.
module ddsc_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned QW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DW-1:0]                 dvd_i,   // left aligned
  input  logic [ddsc_pkg::SR_W-1:0]     dsr_i,
  input  logic [$clog2(DW+1)-1:0]       cnt_i,
  output logic                          done_o,
  output logic [QW-1:0]                 q_o
);

  localparam int unsigned CW = $clog2(DW + 1);
  localparam int unsigned RW = ddsc_pkg::SR_W;

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [DW-1:0]   dvd_q;
  logic [RW-1:0]   dsr_q;
  logic [RW-1:0]   r_q, r_d;
  logic [QW-1:0]   q_q;
  logic [RW:0]     r_sh;
  logic [RW:0]     r_sub;
  logic            ge;

  always_comb begin
    r_sh  = {r_q, dvd_q[DW-1]};
    r_sub = r_sh - {1'b0, dsr_q};
    ge    = (r_sh >= {1'b0, dsr_q});
    r_d   = ge ? r_sub[RW-1:0] : r_sh[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= cnt_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dsr_q <= dsr_i;
      r_q   <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      r_q   <= r_d;
      q_q   <= {q_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

[src/dds_oscillator_with_soft_clip_top.sv]
`timescale 1ns / 1ps
// DDS oscillator with tanh soft clip and output gain; depends on ddsc_pkg, ddsc_mul, ddsc_div.
// Each input word takes up to 9 products on the shared bit-serial multiplier, the increment
// divide (skipped at zero rate) and the gain divide.
// One word at a time, the next taken while a result waits in the output register.
// Reset clears the phase accumulator and loads register defaults.
module dds_oscillator_with_soft_clip_top #(
  parameter int unsigned PHASE_BITS       = ddsc_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = ddsc_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ddsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ddsc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ddsc_pkg::FREQ_W-1:0]         frequency_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ddsc_pkg::SAMPLE_W-1:0] sample_out_o
);

  localparam int unsigned DIV_DW   = PHASE_BITS + 16;
  localparam int unsigned DIV_QW   = (PHASE_BITS > 17) ? PHASE_BITS : 17;
  localparam int unsigned DIV_CW   = $clog2(DIV_DW + 1);
  localparam int unsigned IDX_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned AW       = ddsc_pkg::MUL_AW;
  localparam int unsigned BW       = ddsc_pkg::MUL_BW;
  localparam int unsigned PW       = ddsc_pkg::MUL_PW;
  localparam int unsigned MW       = ddsc_pkg::MAG_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MDET  = 4'd1;
  localparam logic [3:0] ST_MFRQ  = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_WAVE  = 4'd4;
  localparam logic [3:0] ST_SQ    = 4'd5;
  localparam logic [3:0] ST_T1    = 4'd6;
  localparam logic [3:0] ST_T2    = 4'd7;
  localparam logic [3:0] ST_Y     = 4'd8;
  localparam logic [3:0] ST_SHAPE = 4'd9;
  localparam logic [3:0] ST_DRV   = 4'd10;
  localparam logic [3:0] ST_TNH   = 4'd11;
  localparam logic [3:0] ST_GST   = 4'd12;
  localparam logic [3:0] ST_GAIN  = 4'd13;
  localparam logic [3:0] ST_GDIV  = 4'd14;
  localparam logic [3:0] ST_OUT   = 4'd15;

  // configuration registers
  logic [ddsc_pkg::WAVE_W-1:0]   waveform_q;
  logic [ddsc_pkg::DETUNE_W-1:0] detune_q;
  logic [ddsc_pkg::CUTOFF_W-1:0] cutoff_q;
  logic [ddsc_pkg::DIST_W-1:0]   dist_q;
  logic [ddsc_pkg::SR_W-1:0]     sr_q;

  logic [3:0]                    state_q, state_d;
  logic [PHASE_BITS-1:0]         phase_q, phase_d;
  logic [ddsc_pkg::FREQ_W-1:0]   freq_q, freq_d;
  logic [14:0]                   x_q, x_d;
  logic [14:0]                   x2_q, x2_d;
  logic                          neg_q, neg_d;
  logic [MW-1:0]                 mag_q, mag_d;
  logic [3:0]                    k_q, k_d;
  logic                          out_valid_q, out_valid_d;
  logic [ddsc_pkg::SAMPLE_W-1:0] out_data_q, out_data_d;

  logic                          mul_start;
  logic [AW-1:0]                 mul_a;
  logic [BW-1:0]                 mul_b;
  logic                          mul_done;
  logic [PW-1:0]                 mul_p;

  logic                          div_start;
  logic [DIV_DW-1:0]             div_dvd;
  logic [ddsc_pkg::SR_W-1:0]     div_dsr;
  logic [DIV_CW-1:0]             div_cnt;
  logic                          div_done;
  logic [DIV_QW-1:0]             div_q;

  logic [32:0]                   m_rnd;
  logic [AW-1:0]                 m_val;
  logic [PW+PHASE_BITS-1:0]      num_ext;
  logic [15:0]                   f_val;
  logic [14:0]                   x_val;
  logic [15:0]                   saw_t;
  logic [MW-1:0]                 t_val;
  logic [MW-1:0]                 t2_val;
  logic [MW-1:0]                 y_val;
  logic [34:0]                   drv_sum;
  logic [18:0]                   drv_a;
  logic [15:0]                   tanh_d;
  logic [ddsc_pkg::GAIN_W-1:0]   gain_dvd;
  logic [MW-1:0]                 q_mag;
  logic [MW-1:0]                 q_neg;
  logic                          out_free;

  ddsc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  ddsc_div #(
    .DW (DIV_DW),
    .QW (DIV_QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dsr_i   (div_dsr),
    .cnt_i   (div_cnt),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // datapath helpers
  always_comb begin
    m_rnd    = {1'b0, mul_p[31:0]} + 33'd32768;
    m_val    = AW'(1 << 20) + AW'(m_rnd[32:16]);
    num_ext  = {mul_p, {PHASE_BITS{1'b0}}};
    f_val    = 16'(phase_q[PHASE_BITS-1 -: IDX_BITS]) << (16 - IDX_BITS);
    x_val    = f_val[14] ? (15'(ddsc_pkg::QUARTER_Q14) - {1'b0, f_val[13:0]})
                         : {1'b0, f_val[13:0]};
    saw_t    = phase_q[PHASE_BITS-1 -: 16];
    t_val    = MW'(ddsc_pkg::SINE_C3) - mul_p[30:14];
    t2_val   = MW'(ddsc_pkg::SINE_C1) - mul_p[30:14];
    y_val    = mul_p[30:14];
    drv_sum  = {1'b0, mul_p[33:0]} + (neg_q ? 35'd65535 : 35'd0);
    drv_a    = drv_sum[34:16];
    tanh_d   = ddsc_pkg::tanh_pt({1'b0, drv_a[16:13]} + 5'd1)
             - ddsc_pkg::tanh_pt({1'b0, drv_a[16:13]});
    gain_dvd = mul_p[31:0] + 32'(ddsc_pkg::GAIN_HALF);
    q_mag    = div_q[MW-1:0];
    q_neg    = MW'(0) - q_mag;
    out_free = !out_valid_q || out_ready_i;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    freq_d     = freq_q;
    x_d        = x_q;
    x2_d       = x2_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    k_d        = k_q;
    out_data_d = out_data_q;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dsr    = '0;
    div_cnt    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          freq_d    = frequency_i;
          mul_start = 1'b1;
          mul_a     = AW'(ddsc_pkg::DETUNE_SCALE);
          mul_b     = BW'(detune_q);
          state_d   = ST_MDET;
        end
      end
      ST_MDET: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = m_val;
          mul_b     = freq_q;
          state_d   = ST_MFRQ;
        end
      end
      ST_MFRQ: begin
        if (mul_done) begin
          if (sr_q == '0) begin
            state_d = ST_WAVE;
          end else begin
            div_start = 1'b1;
            div_dvd   = num_ext[PW+PHASE_BITS-1:24];
            div_dsr   = sr_q;
            div_cnt   = DIV_CW'(DIV_DW);
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          phase_d = phase_q + div_q[PHASE_BITS-1:0];
          state_d = ST_WAVE;
        end
      end
      ST_WAVE: begin
        unique case (waveform_q)
          ddsc_pkg::WAVE_SINE: begin
            x_d       = x_val;
            neg_d     = f_val[15];
            mul_start = 1'b1;
            mul_a     = AW'(x_val);
            mul_b     = BW'(x_val);
            state_d   = ST_SQ;
          end
          ddsc_pkg::WAVE_SAW: begin
            neg_d   = ~saw_t[15];
            mag_d   = saw_t[15] ? {1'b0, saw_t[14:0], 1'b0}
                                : {16'd32768 - saw_t, 1'b0};
            state_d = ST_SHAPE;
          end
          ddsc_pkg::WAVE_SQUARE: begin
            neg_d   = phase_q[PHASE_BITS-1];
            mag_d   = MW'(ddsc_pkg::ONE_Q16);
            state_d = ST_SHAPE;
          end
          default: begin
            neg_d   = 1'b0;
            mag_d   = '0;
            state_d = ST_SHAPE;
          end
        endcase
      end
      ST_SQ: begin
        if (mul_done) begin
          x2_d      = mul_p[28:14];
          mul_start = 1'b1;
          mul_a     = AW'(ddsc_pkg::SINE_C5);
          mul_b     = BW'(mul_p[28:14]);
          state_d   = ST_T1;
        end
      end
      ST_T1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = AW'(t_val);
          mul_b     = BW'(x2_q);
          state_d   = ST_T2;
        end
      end
      ST_T2: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = AW'(t2_val);
          mul_b     = BW'(x_q);
          state_d   = ST_Y;
        end
      end
      ST_Y: begin
        if (mul_done) begin
          mag_d   = (y_val > MW'(ddsc_pkg::ONE_Q16)) ? MW'(ddsc_pkg::ONE_Q16) : y_val;
          state_d = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        mul_start = 1'b1;
        mul_b     = BW'(mag_q);
        if (dist_q > ddsc_pkg::DIST_W'(ddsc_pkg::DIST_HALF)) begin
          mul_a   = AW'({dist_q, 1'b0});
          state_d = ST_DRV;
        end else begin
          mul_a   = AW'(cutoff_q);
          state_d = ST_GAIN;
        end
      end
      ST_DRV: begin
        if (mul_done) begin
          if (|drv_a[18:17]) begin
            mag_d   = MW'(ddsc_pkg::TANH_LAST);
            state_d = ST_GST;
          end else begin
            k_d       = drv_a[16:13];
            mul_start = 1'b1;
            mul_a     = AW'(tanh_d);
            mul_b     = BW'(drv_a[12:0]);
            state_d   = ST_TNH;
          end
        end
      end
      ST_TNH: begin
        if (mul_done) begin
          mag_d   = MW'(ddsc_pkg::tanh_pt({1'b0, k_q})) + MW'(mul_p[25:13]);
          state_d = ST_GST;
        end
      end
      ST_GST: begin
        mul_start = 1'b1;
        mul_a     = AW'(cutoff_q);
        mul_b     = BW'(mag_q);
        state_d   = ST_GAIN;
      end
      ST_GAIN: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dvd   = DIV_DW'(gain_dvd) << (DIV_DW - ddsc_pkg::GAIN_W);
          div_dsr   = ddsc_pkg::SR_W'(ddsc_pkg::GAIN_DIV);
          div_cnt   = DIV_CW'(ddsc_pkg::GAIN_W);
          state_d   = ST_GDIV;
        end
      end
      ST_GDIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          if (!neg_q) begin
            out_data_d = (q_mag > MW'(32767)) ? 16'h7FFF : q_mag[15:0];
          end else begin
            out_data_d = (q_mag > MW'(32768)) ? 16'h8000 : q_neg[15:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == ST_OUT && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      waveform_q  <= ddsc_pkg::WAVEFORM_RST;
      detune_q    <= ddsc_pkg::DETUNE_RST;
      cutoff_q    <= ddsc_pkg::CUTOFF_RST;
      dist_q      <= ddsc_pkg::DIST_RST;
      sr_q        <= ddsc_pkg::SR_RST;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ddsc_pkg::CFG_WAVEFORM:    waveform_q <= cfg_data_i[ddsc_pkg::WAVE_W-1:0];
          ddsc_pkg::CFG_DETUNE:      detune_q   <= cfg_data_i[ddsc_pkg::DETUNE_W-1:0];
          ddsc_pkg::CFG_CUTOFF:      cutoff_q   <= cfg_data_i[ddsc_pkg::CUTOFF_W-1:0];
          ddsc_pkg::CFG_DISTORTION:  dist_q     <= cfg_data_i[ddsc_pkg::DIST_W-1:0];
          ddsc_pkg::CFG_SAMPLE_RATE: sr_q       <= cfg_data_i[ddsc_pkg::SR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q     <= freq_d;
    x_q        <= x_d;
    x2_q       <= x2_d;
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    k_q        <= k_d;
    out_data_q <= out_data_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

endmodule
